// ===== rtl/core/dfa_pkg.sv =====
// ----------------------------------------------------------------------------
// dfa_pkg
// Shared types, constants and index tables of the dipole field accumulator.
// ----------------------------------------------------------------------------
package dfa_pkg;

	localparam int unsigned FieldW = 48;
	localparam int unsigned CoordW = 32;
	localparam int unsigned AccSumW = 50;

	// 1/(4 pi) in Q0.32
	localparam logic [31:0] INV_FOUR_PI_Q32 = 32'd341782638;
	localparam logic [47:0] LIM_POS = 48'h7FFF_FFFF_FFFF;
	localparam logic [47:0] LIM_NEG = 48'h8000_0000_0000;
	localparam logic signed [7:0] SHIFT_BASE = 8'sd78;

	typedef enum logic [4:0] {
		OP_NOP,
		OP_LOAD,
		OP_PREP,
		OP_NORM,
		OP_SQ_MUL,
		OP_SQ_ADD,
		OP_SQRT_INIT,
		OP_SQRT_STEP,
		OP_DIV_INIT_P,
		OP_DIV_INIT_N,
		OP_DIV_STEP,
		OP_P_SAVE,
		OP_MUL_P2,
		OP_SAVE_P2,
		OP_MUL_P3,
		OP_SAVE_P3,
		OP_MUL_W,
		OP_SAVE_W,
		OP_AA_MUL,
		OP_N_SAVE,
		OP_T_MUL,
		OP_T_SAVE,
		OP_P_LO,
		OP_P_HI,
		OP_P_SUM,
		OP_ACC,
		OP_EMIT
	} dfa_op_t;

	typedef struct packed {
		dfa_op_t    op;
		logic [3:0] idx;
	} dfa_cmd_t;

	typedef struct packed {
		logic self_pair;
		logic zero_dist;
		logic norm_done;
		logic last;
		logic out_busy;
	} dfa_status_t;

	// unique tensor entries: (0,0) (0,1) (0,2) (1,1) (1,2) (2,2)
	function automatic logic [1:0] pair_row(input logic [2:0] p);
		logic [1:0] r;
		case (p)
			3'd0, 3'd1, 3'd2: r = 2'd0;
			3'd3, 3'd4: r = 2'd1;
			default: r = 2'd2;
		endcase
		return r;
	endfunction

	function automatic logic [1:0] pair_col(input logic [2:0] p);
		logic [1:0] c;
		case (p)
			3'd0: c = 2'd0;
			3'd1, 3'd3: c = 2'd1;
			default: c = 2'd2;
		endcase
		return c;
	endfunction

	function automatic logic pair_diag(input logic [2:0] p);
		logic d;
		case (p)
			3'd0, 3'd3, 3'd5: d = 1'b1;
			default: d = 1'b0;
		endcase
		return d;
	endfunction

	// term t = 3*i + j
	function automatic logic [1:0] term_row(input logic [3:0] t);
		logic [1:0] r;
		case (t)
			4'd0, 4'd1, 4'd2: r = 2'd0;
			4'd3, 4'd4, 4'd5: r = 2'd1;
			default: r = 2'd2;
		endcase
		return r;
	endfunction

	function automatic logic [1:0] term_col(input logic [3:0] t);
		logic [1:0] c;
		case (t)
			4'd0, 4'd3, 4'd6: c = 2'd0;
			4'd1, 4'd4, 4'd7: c = 2'd1;
			default: c = 2'd2;
		endcase
		return c;
	endfunction

	function automatic logic [2:0] term_pair(input logic [3:0] t);
		logic [2:0] p;
		case (t)
			4'd0: p = 3'd0;
			4'd1, 4'd3: p = 3'd1;
			4'd2, 4'd6: p = 3'd2;
			4'd4: p = 3'd3;
			4'd5, 4'd7: p = 3'd4;
			default: p = 3'd5;
		endcase
		return p;
	endfunction

endpackage

// ===== rtl/core/dfa_if.sv =====
// ----------------------------------------------------------------------------
// dfa_pair_if / dfa_field_if
// Valid/ready channels for interaction pairs and emitted field results.
// ----------------------------------------------------------------------------
interface dfa_pair_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] target_x;
	logic signed [31:0] target_y;
	logic signed [31:0] target_z;
	logic signed [31:0] source_x;
	logic signed [31:0] source_y;
	logic signed [31:0] source_z;
	logic signed [31:0] moment_x;
	logic signed [31:0] moment_y;
	logic signed [31:0] moment_z;
	logic               is_self_pair;
	logic               last_of_target;

	modport source (
		output valid, target_x, target_y, target_z, source_x, source_y, source_z,
		output moment_x, moment_y, moment_z, is_self_pair, last_of_target,
		input  ready
	);
	modport sink (
		input  valid, target_x, target_y, target_z, source_x, source_y, source_z,
		input  moment_x, moment_y, moment_z, is_self_pair, last_of_target,
		output ready
	);
endinterface

interface dfa_field_if;
	logic               valid;
	logic               ready;
	logic signed [47:0] field_x;
	logic signed [47:0] field_y;
	logic signed [47:0] field_z;
	logic               singular;
	logic               saturated;

	modport source (
		output valid, field_x, field_y, field_z, singular, saturated,
		input  ready
	);
	modport sink (
		input  valid, field_x, field_y, field_z, singular, saturated,
		output ready
	);
endinterface

// ===== rtl/core/dfa_ctrl.sv =====
// ----------------------------------------------------------------------------
// dfa_ctrl
// Sequencer: steps the datapath through normalize, sqrt, divides and terms.
// ----------------------------------------------------------------------------
module dfa_ctrl
	import dfa_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  dfa_status_t status,
	output dfa_cmd_t    cmd
);

	typedef enum logic [10:0] {
		S_IDLE = 11'b000_0000_0001,
		S_PREP = 11'b000_0000_0010,
		S_NORM = 11'b000_0000_0100,
		S_SQ   = 11'b000_0000_1000,
		S_SQRT = 11'b000_0001_0000,
		S_PDIV = 11'b000_0010_0000,
		S_PW   = 11'b000_0100_0000,
		S_NDIV = 11'b000_1000_0000,
		S_TERM = 11'b001_0000_0000,
		S_ACC  = 11'b010_0000_0000,
		S_END  = 11'b100_0000_0000
	} state_t;

	state_t     state_q, state_d;
	logic [5:0] cnt_q, cnt_d;
	logic [3:0] idx_q, idx_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q + 6'd1;
		idx_d = idx_q;
		cmd.op = OP_NOP;
		cmd.idx = idx_q;
		case (state_q)
			S_IDLE: begin
				cnt_d = '0;
				idx_d = '0;
				if (in_valid) begin
					cmd.op = OP_LOAD;
					state_d = S_PREP;
				end
			end
			S_PREP: begin
				cmd.op = OP_PREP;
				cnt_d = '0;
				if (status.self_pair || status.zero_dist) state_d = S_END;
				else state_d = S_NORM;
			end
			S_NORM: begin
				cnt_d = '0;
				if (status.norm_done) state_d = S_SQ;
				else cmd.op = OP_NORM;
			end
			S_SQ: begin
				cmd.idx = {2'b00, cnt_q[2:1]};
				cmd.op = cnt_q[0] ? OP_SQ_ADD : OP_SQ_MUL;
				if (cnt_q == 6'd5) begin
					cnt_d = '0;
					state_d = S_SQRT;
				end
			end
			S_SQRT: begin
				cmd.op = (cnt_q == '0) ? OP_SQRT_INIT : OP_SQRT_STEP;
				if (cnt_q == 6'd32) begin
					cnt_d = '0;
					state_d = S_PDIV;
				end
			end
			S_PDIV: begin
				if (cnt_q == '0) cmd.op = OP_DIV_INIT_P;
				else if (cnt_q == 6'd33) cmd.op = OP_P_SAVE;
				else cmd.op = OP_DIV_STEP;
				if (cnt_q == 6'd33) begin
					cnt_d = '0;
					state_d = S_PW;
				end
			end
			S_PW: begin
				case (cnt_q[2:0])
					3'd0: cmd.op = OP_MUL_P2;
					3'd1: cmd.op = OP_SAVE_P2;
					3'd2: cmd.op = OP_MUL_P3;
					3'd3: cmd.op = OP_SAVE_P3;
					3'd4: cmd.op = OP_MUL_W;
					default: cmd.op = OP_SAVE_W;
				endcase
				if (cnt_q == 6'd5) begin
					cnt_d = '0;
					idx_d = '0;
					state_d = S_NDIV;
				end
			end
			S_NDIV: begin
				if (cnt_q == '0) cmd.op = OP_AA_MUL;
				else if (cnt_q == 6'd1) cmd.op = OP_DIV_INIT_N;
				else if (cnt_q == 6'd34) cmd.op = OP_N_SAVE;
				else cmd.op = OP_DIV_STEP;
				if (cnt_q == 6'd34) begin
					cnt_d = '0;
					idx_d = idx_q + 4'd1;
					if (idx_q == 4'd5) begin
						idx_d = '0;
						state_d = S_TERM;
					end
				end
			end
			S_TERM: begin
				case (cnt_q[2:0])
					3'd0: cmd.op = OP_T_MUL;
					3'd1: cmd.op = OP_T_SAVE;
					3'd2: cmd.op = OP_P_LO;
					3'd3: cmd.op = OP_P_HI;
					default: cmd.op = OP_P_SUM;
				endcase
				if (cnt_q == 6'd4) begin
					cnt_d = '0;
					idx_d = idx_q + 4'd1;
					if (idx_q == 4'd8) state_d = S_ACC;
				end
			end
			S_ACC: begin
				cmd.op = OP_ACC;
				state_d = S_END;
			end
			S_END: begin
				if (!status.last) state_d = S_IDLE;
				else if (!status.out_busy) begin
					cmd.op = OP_EMIT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			idx_q <= '0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
			idx_q <= idx_d;
		end
	end

endmodule

// ===== rtl/core/dfa_datapath.sv =====
// ----------------------------------------------------------------------------
// dfa_datapath
// Shared multiplier, radix-2 divider, bit-pair sqrt, accumulators, output reg.
// ----------------------------------------------------------------------------
module dfa_datapath
	import dfa_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  dfa_cmd_t    cmd,
	output dfa_status_t status,
	dfa_pair_if.sink    pair,
	dfa_field_if.source field
);

	logic signed [32:0] r_q [3];
	logic signed [31:0] m_q [3];
	logic               self_q, last_q;
	logic [32:0]        amag_q [3];
	logic               aneg_q [3];
	logic [32:0]        mx_q;
	logic signed [5:0]  e_q;
	logic [61:0]        s_q;
	logic [62:0]        sq_rem_q, sq_res_q, sq_bit_q;
	logic [60:0]        div_r_q;
	logic [62:0]        div_d_q;
	logic [31:0]        quo_q;
	logic [31:0]        p_q;
	logic [32:0]        p2_q;
	logic [33:0]        p3_q;
	logic [29:0]        w_q;
	logic signed [35:0] g_q [6];
	logic [47:0]        tmag_q;
	logic               tneg_q;
	logic [55:0]        plo_q;
	logic [65:0]        prod_q;
	logic signed [AccSumW-1:0] c_q [3];
	logic signed [FieldW-1:0]  acc_q [3];
	logic               sing_q, sat_q, out_valid_q;

	// index decode
	logic [2:0]  pidx;
	logic [1:0]  ti, tj, pi, pj;
	assign pidx = cmd.idx[2:0];
	assign pi = pair_row(pidx);
	assign pj = pair_col(pidx);
	assign ti = term_row(cmd.idx);
	assign tj = term_col(cmd.idx);

	logic [31:0] mmag;
	logic        mneg;
	assign mneg = m_q[tj][31];
	assign mmag = mneg ? 32'(-m_q[tj]) : 32'(m_q[tj]);

	logic signed [35:0] gsel;
	logic [33:0]        gmag;
	assign gsel = g_q[term_pair(cmd.idx)];
	assign gmag = gsel[35] ? 34'(-gsel) : gsel[33:0];

	// shared multiplier
	logic [33:0] mul_a;
	logic [31:0] mul_b;
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_SQ_MUL: begin
				mul_a = {4'b0, amag_q[cmd.idx[1:0]][29:0]};
				mul_b = {2'b0, amag_q[cmd.idx[1:0]][29:0]};
			end
			OP_MUL_P2: begin
				mul_a = {2'b0, p_q};
				mul_b = p_q;
			end
			OP_MUL_P3: begin
				mul_a = {1'b0, p2_q};
				mul_b = p_q;
			end
			OP_MUL_W: begin
				mul_a = p3_q;
				mul_b = INV_FOUR_PI_Q32;
			end
			OP_AA_MUL: begin
				mul_a = {4'b0, amag_q[pi][29:0]};
				mul_b = {2'b0, amag_q[pj][29:0]};
			end
			OP_T_MUL: begin
				mul_a = gmag;
				mul_b = {2'b0, w_q};
			end
			OP_P_LO: begin
				mul_a = {10'b0, tmag_q[23:0]};
				mul_b = mmag;
			end
			OP_P_HI: begin
				mul_a = {10'b0, tmag_q[47:24]};
				mul_b = mmag;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// tensor term scale: 2^-(78 + 3e)
	logic signed [7:0] e8, sh, nsh;
	logic [63:0]       tm, tsh;
	logic [47:0]       tclip;
	logic              tsat;
	assign e8 = {{2{e_q[5]}}, e_q};
	assign sh = SHIFT_BASE + e8 + e8 + e8;
	assign nsh = -sh;
	assign tm = prod_q[63:0];
	always_comb begin
		if (!sh[7] && sh >= 8'sd64) tsh = '0;
		else if (!sh[7]) tsh = tm >> sh[5:0];
		else if (tm > ({16'b0, LIM_NEG} >> nsh[3:0])) tsh = {16'b0, LIM_NEG} + 64'd1;
		else tsh = tm << nsh[3:0];
		tsat = 1'b0;
		tclip = tsh[47:0];
		if (gsel[35]) begin
			if (tsh > {16'b0, LIM_NEG}) begin
				tclip = LIM_NEG;
				tsat = 1'b1;
			end
		end else if (tsh > {16'b0, LIM_POS}) begin
			tclip = LIM_POS;
			tsat = 1'b1;
		end
	end

	// product term: |T| * |m| / 2^16, then clip
	logic [79:0]        pfull;
	logic [63:0]        pmag;
	logic [47:0]        pclip;
	logic               pneg, psat;
	logic signed [AccSumW-1:0] pval;
	assign pfull = {prod_q[55:0], 24'b0} + {24'b0, plo_q};
	assign pmag = pfull[79:16];
	assign pneg = tneg_q ^ mneg;
	always_comb begin
		psat = 1'b0;
		pclip = pmag[47:0];
		if (pneg) begin
			if (pmag > {16'b0, LIM_NEG}) begin
				pclip = LIM_NEG;
				psat = 1'b1;
			end
		end else if (pmag > {16'b0, LIM_POS}) begin
			pclip = LIM_POS;
			psat = 1'b1;
		end
		pval = pneg ? -$signed({2'b0, pclip}) : $signed({2'b0, pclip});
	end

	// accumulate with saturation
	logic signed [50:0]       asum [3];
	logic signed [FieldW-1:0] anext [3];
	logic [2:0]               asat;
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			asum[i] = 51'(acc_q[i]) + 51'(c_q[i]);
			asat[i] = 1'b0;
			anext[i] = asum[i][47:0];
			if (asum[i] > $signed({3'b0, LIM_POS})) begin
				anext[i] = LIM_POS;
				asat[i] = 1'b1;
			end else if (asum[i] < -$signed({3'b0, LIM_NEG})) begin
				anext[i] = LIM_NEG;
				asat[i] = 1'b1;
			end
		end
	end

	// n_ij with sign, g = 3n - I
	logic signed [35:0] nsig, gval;
	assign nsig = (aneg_q[pi] ^ aneg_q[pj]) ? -$signed({4'b0, quo_q}) : $signed({4'b0, quo_q});
	assign gval = nsig + nsig + nsig - (pair_diag(pidx) ? 36'sh0_4000_0000 : 36'sh0);

	logic [62:0] sq_trial;
	assign sq_trial = sq_res_q + sq_bit_q;

	logic [32:0] rmag [3];
	always_comb begin
		for (int i = 0; i < 3; i++) rmag[i] = r_q[i][32] ? 33'(-r_q[i]) : 33'(r_q[i]);
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				r_q[0] <= 33'(pair.target_x) - 33'(pair.source_x);
				r_q[1] <= 33'(pair.target_y) - 33'(pair.source_y);
				r_q[2] <= 33'(pair.target_z) - 33'(pair.source_z);
				m_q[0] <= pair.moment_x;
				m_q[1] <= pair.moment_y;
				m_q[2] <= pair.moment_z;
				self_q <= pair.is_self_pair;
				last_q <= pair.last_of_target;
			end
			OP_PREP: begin
				for (int i = 0; i < 3; i++) begin
					amag_q[i] <= rmag[i];
					aneg_q[i] <= r_q[i][32];
					c_q[i] <= '0;
				end
				if (rmag[0] >= rmag[1] && rmag[0] >= rmag[2]) mx_q <= rmag[0];
				else if (rmag[1] >= rmag[2]) mx_q <= rmag[1];
				else mx_q <= rmag[2];
				e_q <= '0;
				s_q <= '0;
			end
			OP_NORM: begin
				if (mx_q[32:30] != 3'b0) begin
					for (int i = 0; i < 3; i++) amag_q[i] <= amag_q[i] >> 1;
					mx_q <= mx_q >> 1;
					e_q <= e_q + 6'sd1;
				end else begin
					for (int i = 0; i < 3; i++) amag_q[i] <= amag_q[i] << 1;
					mx_q <= mx_q << 1;
					e_q <= e_q - 6'sd1;
				end
			end
			OP_SQ_ADD: s_q <= s_q + prod_q[61:0];
			OP_SQRT_INIT: begin
				sq_rem_q <= {1'b0, s_q};
				sq_res_q <= '0;
				sq_bit_q <= 63'h4000_0000_0000_0000;
			end
			OP_SQRT_STEP: begin
				if (sq_rem_q >= sq_trial) begin
					sq_rem_q <= sq_rem_q - sq_trial;
					sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
				end else begin
					sq_res_q <= sq_res_q >> 1;
				end
				sq_bit_q <= sq_bit_q >> 2;
			end
			OP_DIV_INIT_P: begin
				div_r_q <= 61'h1000_0000_0000_0000;
				div_d_q <= {1'b0, sq_res_q[30:0], 31'b0};
				quo_q <= '0;
			end
			OP_DIV_INIT_N: begin
				div_r_q <= {1'b0, prod_q[59:0]};
				div_d_q <= {s_q[61:30], 31'b0};
				quo_q <= '0;
			end
			OP_DIV_STEP: begin
				if ({2'b0, div_r_q} >= div_d_q) begin
					div_r_q <= 61'({2'b0, div_r_q} - div_d_q);
					quo_q <= {quo_q[30:0], 1'b1};
				end else begin
					quo_q <= {quo_q[30:0], 1'b0};
				end
				div_d_q <= div_d_q >> 1;
			end
			OP_P_SAVE: p_q <= quo_q;
			OP_SAVE_P2: p2_q <= prod_q[62:30];
			OP_SAVE_P3: p3_q <= prod_q[63:30];
			OP_SAVE_W: w_q <= prod_q[61:32];
			OP_N_SAVE: g_q[pidx] <= gval;
			OP_T_SAVE: begin
				tmag_q <= tclip;
				tneg_q <= gsel[35];
			end
			OP_P_HI: plo_q <= prod_q[55:0];
			OP_P_SUM: c_q[ti] <= c_q[ti] + pval;
			default: ;
		endcase
		case (cmd.op)
			OP_SQ_MUL, OP_MUL_P2, OP_MUL_P3, OP_MUL_W, OP_AA_MUL, OP_T_MUL, OP_P_LO,
			OP_P_HI: prod_q <= mul_a * mul_b;
			default: ;
		endcase
		if (cmd.op == OP_EMIT) begin
			field.field_x <= acc_q[0];
			field.field_y <= acc_q[1];
			field.field_z <= acc_q[2];
			field.singular <= sing_q;
			field.saturated <= sat_q;
		end
	end

	// per-target state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) acc_q[i] <= '0;
			sing_q <= 1'b0;
			sat_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (field.valid && field.ready) out_valid_q <= 1'b0;
			case (cmd.op)
				OP_PREP: if (!self_q && status.zero_dist) sing_q <= 1'b1;
				OP_T_SAVE: if (tsat) sat_q <= 1'b1;
				OP_P_SUM: if (psat) sat_q <= 1'b1;
				OP_ACC: begin
					for (int i = 0; i < 3; i++) acc_q[i] <= anext[i];
					if (asat != 3'b0) sat_q <= 1'b1;
				end
				OP_EMIT: begin
					for (int i = 0; i < 3; i++) acc_q[i] <= '0;
					sing_q <= 1'b0;
					sat_q <= 1'b0;
					out_valid_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	assign field.valid = out_valid_q;
	assign status.self_pair = self_q;
	assign status.zero_dist = (r_q[0] == '0) && (r_q[1] == '0) && (r_q[2] == '0);
	assign status.norm_done = (mx_q[32:30] == 3'b0) && mx_q[29];
	assign status.last = last_q;
	assign status.out_busy = out_valid_q && !field.ready;

endmodule

// ===== rtl/core/dipole_field_accumulator_core.sv =====
// ----------------------------------------------------------------------------
// dipole_field_accumulator_core
// Direct point-dipole interaction: accumulates T*m per target, emits on last.
// ----------------------------------------------------------------------------
//  channel  dir  carries
//  pair     in   target, source, moment, is_self_pair, last_of_target
//  field    out  field_x/y/z (Q24.24), singular, saturated
//
// One pair at a time; pair.ready is high only while the sequencer is idle.
// A regular pair runs n = 0..29 normalize shifts, and its seven 32-step
// divides all go through the one radix-2 divider.
// A self pair or zero-distance pair goes from PREP straight to the end state.
// The result sits in an output register; a stalled field channel holds the
// block only when the next last_of_target pair finishes. Reset is async.
// ----------------------------------------------------------------------------
module dipole_field_accumulator_core
	import dfa_pkg::*;
(
	input logic         clk,
	input logic         arst_n,
	dfa_pair_if.sink    pair,
	dfa_field_if.source field
);

	dfa_cmd_t    cmd;
	dfa_status_t status;

	dfa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pair.valid),
		.in_ready (pair.ready),
		.status   (status),
		.cmd      (cmd)
	);

	dfa_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.status (status),
		.pair   (pair),
		.field  (field)
	);

endmodule

// ===== rtl/core/dfa_checker.sv =====
// ----------------------------------------------------------------------------
// dfa_checker
// Port-level checks on the accumulator core, bound to the top level.
// ----------------------------------------------------------------------------
module dfa_checker
	import dfa_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        pair_valid,
	input logic        pair_ready,
	input logic        field_valid,
	input logic        field_ready,
	input logic [47:0] field_x,
	input logic        field_flag
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		field_valid && !field_ready |=> field_valid)
		else $error("field valid dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		field_valid && !field_ready |=> $stable(field_x) && $stable(field_flag))
		else $error("field payload changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		pair_valid && pair_ready |=> !pair_ready)
		else $error("pair taken while previous pair in work");

	a_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(field_valid) |-> !$past(pair_ready))
		else $error("result emitted without a pair in work");

endmodule

bind dipole_field_accumulator_core dfa_checker u_dfa_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.pair_valid  (pair.valid),
	.pair_ready  (pair.ready),
	.field_valid (field.valid),
	.field_ready (field.ready),
	.field_x     (field.field_x),
	.field_flag  (field.singular)
);

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the dipole field accumulator core. Pairs are driven
// on the pair channel and predicted in fixed point alongside the block; each
// emitted field is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import dfa_pkg::*;

	typedef struct {
		logic signed [31:0] tx, ty, tz;
		logic signed [31:0] sx, sy, sz;
		logic signed [31:0] mx, my, mz;
		logic               self_pair;
		logic               last;
	} pair_item_t;

	typedef struct {
		logic [47:0] fx, fy, fz;
		logic        singular;
		logic        saturated;
	} field_item_t;

	class field_scoreboard;
		longint      acc[3];
		bit          singular_seen, sat_seen;
		field_item_t field_q[$];
		int          errors, checked;

		function new();
			clear_acc();
			errors = 0;
			checked = 0;
		endfunction

		function void clear_acc();
			for (int i = 0; i < 3; i++)
				acc[i] = 0;
			singular_seen = 0;
			sat_seen = 0;
		endfunction

		function int pending();
			return field_q.size();
		endfunction

		function logic [63:0] umag(longint v);
			return v < 0 ? 64'(-v) : 64'(v);
		endfunction

		function logic [63:0] int_sqrt(logic [63:0] s);
			logic [63:0] res, b;
			res = 0;
			b = 64'd1 << 62;
			while (b > s)
				b = b >> 2;
			while (b != 0) begin
				if (s >= res + b) begin
					s = s - (res + b);
					res = (res >> 1) + b;
				end else begin
					res = res >> 1;
				end
				b = b >> 2;
			end
			return res;
		endfunction

		// clip to the 48-bit signed range, flagging saturation
		function longint clip48(logic [63:0] mag, bit neg);
			logic [63:0] lim;
			lim = neg ? 64'(LIM_NEG) : 64'(LIM_POS);
			if (mag > lim) begin
				mag = lim;
				sat_seen = 1;
			end
			return neg ? -longint'(mag) : longint'(mag);
		endfunction

		function longint sat_sum(longint a, longint b);
			longint s;
			s = a + b;
			if (s > longint'(64'(LIM_POS))) begin
				s = longint'(64'(LIM_POS));
				sat_seen = 1;
			end
			if (s < -longint'(64'(LIM_NEG))) begin
				s = -longint'(64'(LIM_NEG));
				sat_seen = 1;
			end
			return s;
		endfunction

		function void add_dipole(longint r[3], longint m[3]);
			longint      a[3], c[3], t[3][3];
			longint      g, v;
			logic [63:0] mx, s, q, p, p2, p3, w, d, mag;
			logic [127:0] prod;
			int          e, k, sh;
			bit          neg;
			mx = 0;
			for (int i = 0; i < 3; i++)
				if (umag(r[i]) > mx) mx = umag(r[i]);
			if (mx == 0) begin
				singular_seen = 1;
				return;
			end
			e = 0;
			if (mx >= (64'd1 << 30)) begin
				while ((mx >> e) >= (64'd1 << 30)) e++;
				for (int i = 0; i < 3; i++) begin
					v = longint'(umag(r[i]) >> e);
					a[i] = r[i] < 0 ? -v : v;
				end
			end else begin
				k = 0;
				while ((mx << k) < (64'd1 << 29)) k++;
				for (int i = 0; i < 3; i++) begin
					v = longint'(umag(r[i]) << k);
					a[i] = r[i] < 0 ? -v : v;
				end
				e = -k;
			end
			s = 0;
			for (int i = 0; i < 3; i++)
				s = s + 64'(a[i] * a[i]);
			q = int_sqrt(s);
			p = (64'd1 << 60) / q;
			p2 = (p * p) >> 30;
			p3 = (p2 * p) >> 30;
			w = (p3 * 64'(INV_FOUR_PI_Q32)) >> 32;
			d = s >> 30;
			sh = 78 + 3 * e;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					g = 3 * ((a[i] * a[j]) / longint'(d));
					if (i == j) g = g - (longint'(1) << 30);
					mag = umag(g) * w;
					if (sh >= 64) mag = 0;
					else if (sh >= 0) mag = mag >> sh;
					else if (mag > (64'(LIM_NEG) >> (-sh))) mag = 64'(LIM_NEG) + 1;
					else mag = mag << (-sh);
					t[i][j] = clip48(mag, g < 0);
				end
			end
			for (int i = 0; i < 3; i++) begin
				c[i] = 0;
				for (int j = 0; j < 3; j++) begin
					neg = (t[i][j] < 0) != (m[j] < 0);
					prod = {64'd0, umag(t[i][j])} * {64'd0, umag(m[j])};
					if (prod[127:80] != 0) mag = 64'(LIM_NEG) + 1;
					else mag = prod[79:16];
					c[i] = c[i] + clip48(mag, neg);
				end
			end
			for (int i = 0; i < 3; i++)
				acc[i] = sat_sum(acc[i], c[i]);
		endfunction

		function void note_pair(pair_item_t it);
			longint      r[3], m[3];
			field_item_t f;
			if (!it.self_pair) begin
				r[0] = longint'(it.tx) - longint'(it.sx);
				r[1] = longint'(it.ty) - longint'(it.sy);
				r[2] = longint'(it.tz) - longint'(it.sz);
				m[0] = longint'(it.mx);
				m[1] = longint'(it.my);
				m[2] = longint'(it.mz);
				add_dipole(r, m);
			end
			if (it.last) begin
				f.fx = acc[0][47:0];
				f.fy = acc[1][47:0];
				f.fz = acc[2][47:0];
				f.singular = singular_seen;
				f.saturated = sat_seen;
				field_q = {field_q, f};
				clear_acc();
			end
		endfunction

		function void check_field(field_item_t got);
			field_item_t exp_f;
			checked++;
			if (field_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("ERROR: field result with nothing outstanding: %h %h %h",
						got.fx, got.fy, got.fz);
				return;
			end
			exp_f = field_q.pop_front();
			if (got.fx !== exp_f.fx || got.fy !== exp_f.fy || got.fz !== exp_f.fz ||
					got.singular !== exp_f.singular || got.saturated !== exp_f.saturated) begin
				errors++;
				if (errors <= 10) begin
					$display("ERROR: field #%0d mismatch", checked);
					$display("  exp x=%h y=%h z=%h sing=%b sat=%b",
						exp_f.fx, exp_f.fy, exp_f.fz, exp_f.singular, exp_f.saturated);
					$display("  got x=%h y=%h z=%h sing=%b sat=%b",
						got.fx, got.fy, got.fz, got.singular, got.saturated);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	dfa_pair_if  pair_ch();
	dfa_field_if field_ch();

	dipole_field_accumulator_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pair   (pair_ch),
		.field  (field_ch)
	);

	field_scoreboard sb;
	int  rx_hold;
	bit  quiet;
	int  pairs_sent;
	int  targets_sent;
	int  singular_targets;

	initial clk = 1'b0;
	always #1 clk = ~clk;

	initial begin
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

	function automatic pair_item_t mk(int tx, int ty, int tz, int sx, int sy, int sz,
			int mx, int my, int mz, bit self_p, bit last);
		pair_item_t it;
		it.tx = tx; it.ty = ty; it.tz = tz;
		it.sx = sx; it.sy = sy; it.sz = sz;
		it.mx = mx; it.my = my; it.mz = mz;
		it.self_pair = self_p;
		it.last = last;
		return it;
	endfunction

	task automatic send_pair(pair_item_t it);
		bit took;
		pair_ch.valid          <= 1'b1;
		pair_ch.target_x       <= it.tx;
		pair_ch.target_y       <= it.ty;
		pair_ch.target_z       <= it.tz;
		pair_ch.source_x       <= it.sx;
		pair_ch.source_y       <= it.sy;
		pair_ch.source_z       <= it.sz;
		pair_ch.moment_x       <= it.mx;
		pair_ch.moment_y       <= it.my;
		pair_ch.moment_z       <= it.mz;
		pair_ch.is_self_pair   <= it.self_pair;
		pair_ch.last_of_target <= it.last;
		took = 0;
		while (!took) begin
			@(negedge clk);
			took = pair_ch.ready;
			@(posedge clk);
		end
		sb.note_pair(it);
		pairs_sent++;
		if (it.last) targets_sent++;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			pair_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	// stop offering pairs, then wait for every outstanding field
	task automatic wait_drained();
		pair_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	function automatic int rand_coord();
		int v;
		case ($urandom_range(0, 3))
			0: v = $urandom();
			1: v = $signed($urandom_range(0, 2000)) - 1000;
			default: v = ($signed($urandom_range(0, 65535)) - 32768) <<< $urandom_range(0, 15);
		endcase
		return v;
	endfunction

	function automatic int rand_moment();
		int v;
		if ($urandom_range(0, 2) == 0) v = $urandom();
		else v = ($signed($urandom_range(0, 4095)) - 2048) <<< $urandom_range(0, 14);
		return v;
	endfunction

	// one target: a run of pairs sharing the target position
	task automatic send_target(int n);
		pair_item_t it;
		int tx, ty, tz, sx, sy, sz, mode;
		tx = rand_coord(); ty = rand_coord(); tz = rand_coord();
		for (int i = 0; i < n; i++) begin
			mode = $urandom_range(0, 19);
			if (mode < 2) begin
				sx = tx; sy = ty; sz = tz;
			end else if (mode < 10) begin
				sx = tx + rand_coord() / ($urandom_range(0, 1) ? 1 : 256);
				sy = ty + rand_coord() / ($urandom_range(0, 1) ? 1 : 256);
				sz = tz + rand_coord() / ($urandom_range(0, 1) ? 1 : 256);
			end else begin
				sx = $urandom(); sy = $urandom(); sz = $urandom();
			end
			it = mk(tx, ty, tz, sx, sy, sz, rand_moment(), rand_moment(), rand_moment(),
				($urandom_range(0, 9) == 0) || (mode == 0), i == n - 1);
			if (it.last && it.self_pair == 0 && mode < 2) singular_targets++;
			send_pair(it);
		end
	endtask

	initial begin : receiver
		field_item_t got;
		bit take;
		int gap;
		gap = 0;
		field_ch.ready <= 1'b0;
		forever begin
			@(negedge clk);
			take = field_ch.valid && field_ch.ready;
			got.fx = field_ch.field_x;
			got.fy = field_ch.field_y;
			got.fz = field_ch.field_z;
			got.singular = field_ch.singular;
			got.saturated = field_ch.saturated;
			@(posedge clk);
			if (take) sb.check_field(got);
			if (rx_hold > 0) begin
				rx_hold--;
				field_ch.ready <= 1'b0;
			end else if (gap > 0) begin
				gap--;
				field_ch.ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				gap = $urandom_range(1, 3) - 1;
				field_ch.ready <= 1'b0;
			end else begin
				field_ch.ready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		sb = new();
		rx_hold = 0;
		quiet = 0;
		pairs_sent = 0;
		targets_sent = 0;
		singular_targets = 0;
		arst_n = 1'b0;
		pair_ch.valid <= 1'b0;
		pair_ch.target_x <= 0; pair_ch.target_y <= 0; pair_ch.target_z <= 0;
		pair_ch.source_x <= 0; pair_ch.source_y <= 0; pair_ch.source_z <= 0;
		pair_ch.moment_x <= 0; pair_ch.moment_y <= 0; pair_ch.moment_z <= 0;
		pair_ch.is_self_pair <= 1'b0;
		pair_ch.last_of_target <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: self pairs, zero distance, extremes, saturation, thresholds
		send_pair(mk(0, 0, 0, 0, 0, 0, 32'h10000, 0, 0, 1, 1));
		send_pair(mk(5, 6, 7, 5, 6, 7, 32'h10000, 32'h10000, 0, 0, 1));
		send_pair(mk(100, 0, 0, 0, 0, 0, 32'h10000, 0, 0, 1, 0));
		send_pair(mk(32'h10000, 0, 0, 0, 0, 0, 32'h10000, 0, 0, 0, 1));
		send_pair(mk(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
			32'h80000000, 32'h80000000, 32'h80000000,
			32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 1));
		send_pair(mk(32'h80000000, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 32'h80000000,
			32'h80000000, 32'h80000000, 32'h80000000, 0, 1));
		send_pair(mk(1, 0, 0, 0, 0, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 1));
		send_pair(mk(1, 1, 1, 0, 0, 0, 32'h80000000, 32'h80000000, 32'h80000000, 0, 1));
		send_pair(mk(0, -32'h30000, 0, 0, 0, 0, 32'h10000, 32'h10000, 32'h10000, 0, 1));
		send_pair(mk(0, 0, 3, 0, 0, 0, 32'h7FFFFFFF, 0, 0, 0, 0));
		send_pair(mk(0, 0, 3, 0, 0, 0, 32'h7FFFFFFF, 0, 0, 0, 0));
		send_pair(mk(0, 0, 3, 0, 0, 0, 32'h7FFFFFFF, 0, 0, 0, 1));
		send_pair(mk(9, 9, 9, 9, 9, 9, 0, 0, 0, 0, 0));
		send_pair(mk(32'h20000, 32'h10000, 0, 0, 0, 0, 32'h10000, 0, 32'h10000, 0, 1));
		send_pair(mk(32'h40000000, 0, 0, 0, 0, 0, 32'h10000, 32'h10000, 0, 0, 1));
		send_pair(mk(32'h20000000, 0, 0, 0, 0, 0, 0, 32'h10000, 0, 0, 1));
		send_pair(mk(32'h3FFFFFFF, 32'h12345, -32'h54321, 0, 0, 0, 0, 0, 0, 0, 1));
		send_pair(mk(3, 0, 0, 0, 4, 0, 32'h18000, -32'h8000, 32'h4000, 0, 1));

		// receiver holds off while targets keep coming, then sender waits for drain
		wait_drained();
		rx_hold = 2500;
		for (int i = 0; i < 4; i++) send_target(1);
		wait_drained();

		while (pairs_sent < 400) begin
			if (pairs_sent >= 320) quiet = 1;
			send_target($urandom_range(1, 5));
		end

		wait_drained();
		repeat (400) @(posedge clk);
		$display("Run covered %0d pairs over %0d targets (%0d ending on a zero-distance pair),",
			pairs_sent, targets_sent, singular_targets);
		$display("with self pairs, extreme coordinates, clipping and a long output stall.");
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// ===== dipole_field_accumulator_core.f =====
rtl/core/dfa_pkg.sv
rtl/core/dfa_if.sv
rtl/core/dfa_ctrl.sv
rtl/core/dfa_datapath.sv
rtl/core/dipole_field_accumulator_core.sv
rtl/core/dfa_checker.sv
tb/tb_top.sv
